FILE: rtl/mrpa_pkg.sv
package mrpa_pkg;

    localparam int NUM_BANDS = 10;
    localparam int COEF_BITS = 16;
    localparam int OUT_BITS  = 16;

    typedef logic [COEF_BITS-1:0] coef_t;
    typedef logic [OUT_BITS-1:0]  q8_8_t;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_CORRECT = 1'b1;

    localparam q8_8_t OUT_MAX = 16'hFFFF;

    // band edges as fractions of the frame maximum, Q0.16, ascending
    localparam coef_t BAND_FRAC [NUM_BANDS] = '{
        16'd32768, 16'd36045, 16'd38666, 16'd41288, 16'd42598,
        16'd43254, 16'd43909, 16'd44564, 16'd45220, 16'd45875
    };

    // gain applied inside each band, Q0.16
    localparam coef_t BAND_GAIN [NUM_BANDS] = '{
        16'd45875, 16'd49152, 16'd52429, 16'd55706, 16'd58982,
        16'd61604, 16'd63570, 16'd64881, 16'd65208, 16'd65470
    };

endpackage

FILE: rtl/max_relative_pixel_attenuation.sv
// channel | handshake           | payload                  | direction
// --------+---------------------+--------------------------+----------
// in      | in_valid / in_stall | op, pixel, frame_start   | into block
// out     | out_valid/out_stall | corrected                | out of block
//
// one word per cycle while in_stall is low; a correct-pass word passes the input stage, then the result register
// measure-pass words give no result and never wait on the output side
// per-band thresholds are refreshed with the frame maximum, so the pixel path is
// one compare bank, one pixel x gain multiply and a rounding add
// reset clears the frame maximum and its thresholds to zero and empties both stages
// out_stall holds the result register; in_stall rises only when a correct-pass word
// waits behind a held result
module max_relative_pixel_attenuation #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [PIXEL_BITS-1:0] pixel,
    input  logic                  frame_start,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           corrected
);
    import mrpa_pkg::*;

    localparam int PROD_BITS = PIXEL_BITS + COEF_BITS;
    localparam int RND_BITS  = PIXEL_BITS + 8;

    typedef logic [PIXEL_BITS-1:0] pix_t;

    // input stage
    logic s1_valid_reg, s1_valid_next;
    logic s1_op_reg;
    pix_t s1_pixel_reg;
    logic s1_fs_reg;

    // frame state
    pix_t frame_max_reg, frame_max_next;
    pix_t thr_reg  [NUM_BANDS];
    pix_t thr_next [NUM_BANDS];

    // result stage
    logic  out_valid_reg, out_valid_next;
    q8_8_t corrected_reg, corrected_next;

    logic out_free;
    logic s1_go;
    logic in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && (s1_op_reg == OP_MEASURE || out_free);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next = in_take || (s1_valid_reg && !s1_go);

    // running maximum and the band thresholds that follow from it
    always_comb
    begin
        logic [PROD_BITS-1:0] prod;
        frame_max_next = frame_max_reg;
        if (s1_go && s1_op_reg == OP_MEASURE &&
            (s1_fs_reg || s1_pixel_reg > frame_max_reg))
        begin
            frame_max_next = s1_pixel_reg;
        end
        for (int b = 0; b < NUM_BANDS; b++)
        begin
            // pixel * 2^16 <= frac * max  <=>  pixel <= floor(frac * max / 2^16)
            prod        = PROD_BITS'(BAND_FRAC[b]) * PROD_BITS'(frame_max_next);
            thr_next[b] = prod[PROD_BITS-1:COEF_BITS];
        end
    end

    // band pick, scale and round
    always_comb
    begin
        coef_t                gain;
        logic                 hit;
        logic [PROD_BITS-1:0] prod;
        logic [RND_BITS-1:0]  scaled;
        hit  = 1'b0;
        gain = BAND_GAIN[0];
        // walk down so the lowest matching band wins
        for (int b = NUM_BANDS - 1; b >= 0; b--)
        begin
            if (s1_pixel_reg <= thr_reg[b])
            begin
                hit  = 1'b1;
                gain = BAND_GAIN[b];
            end
        end
        prod = PROD_BITS'(s1_pixel_reg) * PROD_BITS'(gain);
        if (hit)
        begin
            scaled = RND_BITS'((prod + PROD_BITS'(128)) >> 8);
        end
        else
        begin
            scaled = {s1_pixel_reg, 8'd0};
        end
        if (scaled > RND_BITS'(OUT_MAX))
        begin
            corrected_next = OUT_MAX;
        end
        else
        begin
            corrected_next = scaled[OUT_BITS-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (s1_go && s1_op_reg == OP_CORRECT)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            frame_max_reg <= '0;
            for (int b = 0; b < NUM_BANDS; b++)
            begin
                thr_reg[b] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            frame_max_reg <= frame_max_next;
            for (int b = 0; b < NUM_BANDS; b++)
            begin
                thr_reg[b] <= thr_next[b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            s1_op_reg    <= op;
            s1_pixel_reg <= pixel;
            s1_fs_reg    <= frame_start;
        end
        if (s1_go && s1_op_reg == OP_CORRECT)
        begin
            corrected_reg <= corrected_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign corrected = corrected_reg;

endmodule

FILE: rtl/mrpa_checker.sv
module mrpa_checker #(
    parameter int PIXEL_BITS = 8
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  op,
    input logic [PIXEL_BITS-1:0] pixel,
    input logic                  frame_start,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [15:0]           corrected
);
    import mrpa_pkg::*;

    // a held result word keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(corrected))
        else $error("held result word changed");

    // the input side only waits behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with the output free");

    // a fresh result comes from a correct-pass word that passed the input stage and the result register
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && op == OP_CORRECT, 2))
        else $error("result word without a correct-pass word");

    // with 8-bit pixels the gain never exceeds one
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (PIXEL_BITS > 8) || (corrected <= 16'hFF00))
        else $error("result above the largest pixel");

endmodule

bind max_relative_pixel_attenuation mrpa_checker #(.PIXEL_BITS(PIXEL_BITS)) u_mrpa_checker (.*);

FILE: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrpa_pkg::*;

    localparam int PIXEL_BITS   = 8;
    localparam int TARGET_WORDS = 1550;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 400;
    localparam int DRAIN_AT     = 800;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    class attenuation_scoreboard;
        pixel_t frame_max;
        q8_8_t  expected_corrected[$];
        int     errors;

        function new();
            frame_max = '0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_corrected.size();
        endfunction

        // band search against the running maximum, gain product rounded to Q8.8
        function q8_8_t attenuate(pixel_t px);
            longint unsigned scaled;
            longint unsigned bound;
            longint unsigned prod;
            scaled = px;
            scaled = scaled << 16;
            for (int b = 0; b < NUM_BANDS; b++)
            begin
                bound = BAND_FRAC[b];
                bound = bound * frame_max;
                if (scaled <= bound)
                begin
                    prod = px;
                    prod = (prod * BAND_GAIN[b] + 128) >> 8;
                    return (prod > OUT_MAX) ? OUT_MAX : q8_8_t'(prod);
                end
            end
            prod = px;
            prod = prod << 8;
            return (prod > OUT_MAX) ? OUT_MAX : q8_8_t'(prod);
        endfunction

        function void note_word(logic op_w, pixel_t px, logic fs);
            if (op_w == OP_MEASURE)
            begin
                if (fs || px > frame_max)
                    frame_max = px;
            end
            else
                expected_corrected.push_back(attenuate(px));
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(q8_8_t got);
            q8_8_t want;
            if (expected_corrected.size() == 0)
            begin
                report_mismatch($sformatf("unexpected corrected 0x%04h", got));
                return;
            end
            want = expected_corrected.pop_front();
            if (got !== want)
                report_mismatch($sformatf("corrected 0x%04h, expected 0x%04h", got, want));
        endtask
    endclass

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   in_valid    = 1'b0;
    logic   in_stall;
    logic   op          = OP_MEASURE;
    pixel_t pixel       = '0;
    logic   frame_start = 1'b0;
    logic   out_valid;
    logic   out_stall   = 1'b0;
    logic [15:0] corrected;

    attenuation_scoreboard sb = new();

    int   words_sent = 0;
    int   burst_left = 0;
    bit   hold_req   = 1'b0;
    bit   hold_done  = 1'b0;
    bit   drained    = 1'b0;

    max_relative_pixel_attenuation #(
        .PIXEL_BITS(PIXEL_BITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .pixel      (pixel),
        .frame_start(frame_start),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .corrected  (corrected)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            sb.note_word(op, pixel, frame_start);
        if (out_valid && !out_stall)
            sb.check_result(corrected);
    end

    // receiver: stall pattern changes every stretch, plus one long hold-off
    initial
    begin
        int mode;
        int mode_left;
        int period;
        int cnt;
        mode      = 0;
        mode_left = 0;
        period    = 2;
        cnt       = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req  = 1'b0;
                hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
                period    = $urandom_range(2, 9);
            end
            mode_left--;
            cnt++;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ((cnt % period) < (period / 2));
            endcase
        end
    end

    task drive_word(logic op_w, pixel_t px, logic fs);
        if (burst_left == 0)
        begin
            // no gaps while the output is held, so the block backs up
            if (!hold_req && $urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid    <= 1'b1;
        op          <= op_w;
        pixel       <= px;
        frame_start <= fs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic pixel_t clip_pixel(int v);
        if (v < 0)
            return '0;
        if (v > 255)
            return 8'd255;
        return pixel_t'(v);
    endfunction

    // measure words from frame start, then correct words, half of them aimed at the band edges
    task send_frame();
        int     n_measure;
        int     n_correct;
        int     ceiling;
        int     mx;
        int     lo;
        int     hi;
        int     sel;
        pixel_t px;
        n_measure = $urandom_range(1, 12);
        n_correct = $urandom_range(1, 24);
        sel       = $urandom_range(0, 9);
        ceiling   = (sel == 0) ? 255 : (sel == 1) ? $urandom_range(0, 8) : $urandom_range(0, 255);
        mx        = 0;
        for (int i = 0; i < n_measure; i++)
        begin
            px = pixel_t'($urandom_range(0, ceiling));
            if (i == 0 || int'(px) > mx)
                mx = int'(px);
            drive_word(OP_MEASURE, px, i == 0);
        end
        lo = mx / 2 - 2;
        hi = ((mx * 45875) >> 16) + 2;
        for (int i = 0; i < n_correct; i++)
        begin
            sel = $urandom_range(0, 7);
            if (sel < 4)
                px = clip_pixel($urandom_range(lo < 0 ? 0 : lo, hi));
            else if (sel < 6)
                px = pixel_t'($urandom_range(0, 255));
            else if (sel == 6)
                px = pixel_t'(mx);
            else
                px = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
            drive_word(OP_CORRECT, px, 1'($urandom_range(0, 1)));
        end
    endtask

    task send_noise();
        int n;
        n = $urandom_range(1, 20);
        repeat (n)
            drive_word(1'($urandom_range(0, 1)), pixel_t'($urandom_range(0, 255)),
                       $urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // correct words before any measure see a zero maximum
        drive_word(OP_CORRECT, 8'd0, 1'b0);
        drive_word(OP_CORRECT, 8'd255, 1'b1);
        // frame start resets the maximum even to a smaller value
        drive_word(OP_MEASURE, 8'd255, 1'b1);
        drive_word(OP_MEASURE, 8'd0, 1'b1);
        drive_word(OP_MEASURE, 8'd200, 1'b0);
        drive_word(OP_MEASURE, 8'd13, 1'b0);
        // walk through the band edges of a maximum of 200
        drive_word(OP_CORRECT, 8'd100, 1'b0);
        drive_word(OP_CORRECT, 8'd101, 1'b0);
        drive_word(OP_CORRECT, 8'd110, 1'b1);
        drive_word(OP_CORRECT, 8'd118, 1'b0);
        drive_word(OP_CORRECT, 8'd126, 1'b0);
        drive_word(OP_CORRECT, 8'd130, 1'b0);
        drive_word(OP_CORRECT, 8'd132, 1'b0);
        drive_word(OP_CORRECT, 8'd134, 1'b0);
        drive_word(OP_CORRECT, 8'd136, 1'b0);
        drive_word(OP_CORRECT, 8'd138, 1'b0);
        drive_word(OP_CORRECT, 8'd140, 1'b0);
        drive_word(OP_CORRECT, 8'd141, 1'b0);
        drive_word(OP_CORRECT, 8'd200, 1'b0);
        drive_word(OP_CORRECT, 8'd0, 1'b0);
        drive_word(OP_MEASURE, 8'd255, 1'b0);
        drive_word(OP_CORRECT, 8'd255, 1'b0);
        drive_word(OP_CORRECT, 8'd178, 1'b0);
        drive_word(OP_CORRECT, 8'd179, 1'b0);
        wait_drained();

        while (words_sent < TARGET_WORDS)
        begin
            if (!hold_done && !hold_req && words_sent >= HOLD_AT)
                hold_req = 1'b1;
            if (!drained && words_sent >= DRAIN_AT)
            begin
                wait_drained();
                drained = 1'b1;
            end
            if ($urandom_range(0, 99) < 85)
                send_frame();
            else
                send_noise();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
rtl/mrpa_pkg.sv
rtl/max_relative_pixel_attenuation.sv
rtl/mrpa_checker.sv
verif/tb_top.sv
